### design/waveform_table_sample_generator_top_assert.svh
// Assertion macros for the waveform table sample generator.
// Each macro expects signals named clk and rst_n in the enclosing scope.
`ifndef WAVEFORM_TABLE_SAMPLE_GENERATOR_TOP_ASSERT_SVH
`define WAVEFORM_TABLE_SAMPLE_GENERATOR_TOP_ASSERT_SVH

`ifndef ASSERT_OFF

// Same-cycle implication.
`define WTSG_ASSERT_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Implication after a fixed number of cycles.
`define WTSG_ASSERT_DELAY(lbl, ante, dly, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##dly (cons)) \
        else $error(msg);

`else

`define WTSG_ASSERT_IMPLY(lbl, ante, cons, msg)
`define WTSG_ASSERT_DELAY(lbl, ante, dly, cons, msg)

`endif

`endif

### design/wtsg_pkg.sv
package wtsg_pkg;

    // Waveform geometry
    localparam int PERIOD_STEPS = 48;
    localparam int HALF_STEPS   = PERIOD_STEPS / 2;
    localparam int PHASE_W      = 6;
    localparam int IDX_W        = $clog2(PERIOD_STEPS);
    localparam int NUM_SHAPES   = 4;

    // Field and register widths
    localparam int SHAPE_W    = 2;
    localparam int AMP_W      = 14;
    localparam int OFFS_W     = 14;
    localparam int CODE_W     = 16;
    localparam int WAVE_W     = 17;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 14;

    // Scaling constants
    localparam int UNIT_Q15   = 32768;
    localparam int MID_CODE   = 32759;
    localparam int MAX_CODE   = 65518;
    localparam int OFFS_SHIFT = 16;

    // Common denominator 32768 * 10000 = 2^19 * 625
    localparam int DEN_SHIFT = 19;
    localparam int DEN_ODD   = 625;

    // Datapath widths
    localparam int PROD_W      = WAVE_W + AMP_W + 1;
    localparam int TERM_W      = 33;
    localparam int MAG_W       = 31;
    localparam int MID_W       = 15;
    localparam int NUM_W       = MID_W + MAG_W;
    localparam int SHR_W       = NUM_W - DEN_SHIFT;
    localparam int RECIP_W     = 28;
    localparam int RECIP_SHIFT = SHR_W + 10;
    localparam int PQ_W        = SHR_W + RECIP_W;
    localparam int QUOT_W      = PQ_W - RECIP_SHIFT;

    localparam logic signed [TERM_W-1:0] DEN_TERM = TERM_W'(UNIT_Q15 * 10000);
    localparam logic [RECIP_W-1:0] RECIP_ODD =
        RECIP_W'(((64'd1 << RECIP_SHIFT) + 64'(DEN_ODD) - 64'd1) / 64'(DEN_ODD));
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

    typedef enum logic [SHAPE_W-1:0] {
        SHAPE_SQUARE,
        SHAPE_TRIANGLE,
        SHAPE_SINE,
        SHAPE_RAMP
    } shape_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_WAVE_SHAPE,
        REG_AMPLITUDE,
        REG_OFFSET,
        REG_UNUSED
    } reg_index_t;

    typedef logic signed [WAVE_W-1:0] wave_t;
    typedef logic [NUM_SHAPES-1:0][PERIOD_STEPS-1:0][WAVE_W-1:0] wave_tab_t;

    // sin(2*pi*i/P) in Q.15 by quadrant folding and a Taylor series in Q2.30
    function automatic int sine_q15(int i);
        longint unsigned u;
        longint unsigned quad;
        longint unsigned r;
        longint unsigned x;
        longint unsigned x2;
        longint unsigned term;
        longint          sum;
        int              v;
        u    = 64'(4 * i);
        quad = u / PERIOD_STEPS;
        r    = u % PERIOD_STEPS;
        if (quad[0])
        begin
            r = 64'(PERIOD_STEPS) - r;
        end
        x    = (HALF_PI_Q30 * r) / PERIOD_STEPS;
        x2   = (x * x) >> 30;
        term = x;
        sum  = longint'(x);
        term = ((term * x2) >> 30) / 6;
        sum  = sum - longint'(term);
        term = ((term * x2) >> 30) / 20;
        sum  = sum + longint'(term);
        term = ((term * x2) >> 30) / 42;
        sum  = sum - longint'(term);
        term = ((term * x2) >> 30) / 72;
        sum  = sum + longint'(term);
        term = ((term * x2) >> 30) / 110;
        sum  = sum - longint'(term);
        if (sum < 0)
        begin
            sum = 0;
        end
        v = int'((sum + 16384) >> 15);
        if (v > UNIT_Q15)
        begin
            v = UNIT_Q15;
        end
        return quad[1] ? -v : v;
    endfunction

    // Unit wave of every shape at every phase step, Q.15
    function automatic wave_tab_t build_wave_tab();
        wave_tab_t tab;
        int        v;
        for (int n = 0; n < PERIOD_STEPS; n++)
        begin
            tab[SHAPE_SQUARE][n] = WAVE_W'((n < HALF_STEPS) ? UNIT_Q15 : -UNIT_Q15);
            if (n < HALF_STEPS)
            begin
                v = (UNIT_Q15 * (HALF_STEPS - 2 * n)) / HALF_STEPS;
            end
            else
            begin
                v = (UNIT_Q15 * (2 * (n - HALF_STEPS) - HALF_STEPS)) / HALF_STEPS;
            end
            tab[SHAPE_TRIANGLE][n] = WAVE_W'(v);
            tab[SHAPE_SINE][n]     = WAVE_W'(sine_q15(n));
            tab[SHAPE_RAMP][n]     = WAVE_W'((UNIT_Q15 * (HALF_STEPS - n)) / HALF_STEPS);
        end
        return tab;
    endfunction

    localparam wave_tab_t WAVE_TAB = build_wave_tab();

endpackage

### design/waveform_table_sample_generator_top.sv
// Channel        Ports                                  Transaction completes
// -------------  -------------------------------------  -------------------------------
// sample in      start, busy, phase_index               rising edge, start & !busy
// sample out     done, dac_code                         rising edge ending the done cycle
// config write   cfg_wr_en, cfg_index, cfg_data         rising edge with cfg_wr_en high
//
// Takes one phase index every cycle; busy stays low.
// Each result leaves in order, one per cycle, through the registers behind the
// phase fold, the table read, the amplitude product, the bias and offset term,
// the midscale multiply, the reciprocal divide and the clamp.
// rst_n clears the valid pipe and the configuration registers at once.
// The receiver cannot stall: done is a one-cycle strobe.
`include "waveform_table_sample_generator_top_assert.svh"

module waveform_table_sample_generator_top
    import wtsg_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic [PHASE_W-1:0]    phase_index,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output logic                  done,
    output logic [CODE_W-1:0]     dac_code
);

    // Cycles from an input transaction to its done strobe
    localparam int PIPE_LATENCY = 7;

    shape_t                     wave_shape_reg;
    logic [AMP_W-1:0]           amplitude_reg;
    logic signed [OFFS_W-1:0]   offset_reg;

    logic                       accept;
    logic                       wave_valid;
    wave_t                      wave;
    logic                       term_valid;
    logic signed [TERM_W-1:0]   term;

    // The pipeline never fills up, so never hold off a start
    assign busy   = 1'b0;
    assign accept = start & ~busy;

    // Configuration registers; drop writes to indexes beyond the list
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wave_shape_reg <= SHAPE_SQUARE;
            amplitude_reg  <= '0;
            offset_reg     <= '0;
        end
        else if (cfg_wr_en)
        begin
            case (reg_index_t'(cfg_index))
                REG_WAVE_SHAPE: wave_shape_reg <= shape_t'(cfg_data[SHAPE_W-1:0]);
                REG_AMPLITUDE:  amplitude_reg  <= cfg_data[AMP_W-1:0];
                REG_OFFSET:     offset_reg     <= $signed(cfg_data[OFFS_W-1:0]);
                default:        ;
            endcase
        end
    end

    // Stages 1-2: fold the phase, look up the unit wave
    wtsg_wave u_wave
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (accept),
        .phase_index (phase_index),
        .wave_shape  (wave_shape_reg),
        .out_valid   (wave_valid),
        .wave        (wave)
    );

    // Stages 3-4: amplitude product, then bias and offset over the common denominator
    wtsg_scale u_scale
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (wave_valid),
        .wave      (wave),
        .amplitude (amplitude_reg),
        .offset    (offset_reg),
        .out_valid (term_valid),
        .term      (term)
    );

    // Stages 5-7: midscale multiply, reciprocal divide, clamp into the output register
    wtsg_div u_div
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (term_valid),
        .term      (term),
        .out_valid (done),
        .dac_code  (dac_code)
    );

    // Every transaction yields exactly one strobe, a fixed latency later
    `WTSG_ASSERT_DELAY(a_result_follows, accept, PIPE_LATENCY, done, "result missing")
    `WTSG_ASSERT_DELAY(a_no_spurious, !accept, PIPE_LATENCY, !done, "spurious result")
    // Clamp holds the top code
    `WTSG_ASSERT_IMPLY(a_code_clamped, done, dac_code <= CODE_W'(MAX_CODE), "code over max")

endmodule

### design/wtsg_wave.sv
module wtsg_wave
    import wtsg_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic [PHASE_W-1:0] phase_index,
    input  shape_t             wave_shape,
    output logic               out_valid,
    output wave_t              wave
);

    logic             idx_valid_reg;
    logic [IDX_W-1:0] idx_next;
    logic [IDX_W-1:0] idx_reg;
    logic             wave_valid_reg;
    wave_t            wave_next;
    wave_t            wave_reg;

    // Fold an out-of-range phase back into the period
    always_comb
    begin
        if (phase_index >= PHASE_W'(PERIOD_STEPS))
        begin
            idx_next = IDX_W'(phase_index - PHASE_W'(PERIOD_STEPS));
        end
        else
        begin
            idx_next = IDX_W'(phase_index);
        end
    end

    assign wave_next = $signed(WAVE_TAB[wave_shape][idx_reg]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_valid_reg  <= 1'b0;
            wave_valid_reg <= 1'b0;
        end
        else
        begin
            idx_valid_reg  <= in_valid;
            wave_valid_reg <= idx_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg  <= idx_next;
        wave_reg <= wave_next;
    end

    assign out_valid = wave_valid_reg;
    assign wave      = wave_reg;

endmodule

### design/wtsg_scale.sv
module wtsg_scale
    import wtsg_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    input  wave_t                    wave,
    input  logic [AMP_W-1:0]         amplitude,
    input  logic signed [OFFS_W-1:0] offset,
    output logic                     out_valid,
    output logic signed [TERM_W-1:0] term
);

    logic                     prod_valid_reg;
    logic signed [PROD_W-1:0] prod_next;
    logic signed [PROD_W-1:0] prod_reg;
    logic                     term_valid_reg;
    logic signed [TERM_W-1:0] term_next;
    logic signed [TERM_W-1:0] term_reg;

    // Scale the unit wave by the amplitude
    assign prod_next = PROD_W'(wave) * PROD_W'($signed({1'b0, amplitude}));

    // Add the midscale bias and drop the offset, all over the common denominator
    assign term_next = TERM_W'(prod_reg) + DEN_TERM - (TERM_W'(offset) <<< OFFS_SHIFT);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_valid_reg <= 1'b0;
            term_valid_reg <= 1'b0;
        end
        else
        begin
            prod_valid_reg <= in_valid;
            term_valid_reg <= prod_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        term_reg <= term_next;
    end

    assign out_valid = term_valid_reg;
    assign term      = term_reg;

endmodule

### design/wtsg_div.sv
module wtsg_div
    import wtsg_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    input  logic signed [TERM_W-1:0] term,
    output logic                     out_valid,
    output logic [CODE_W-1:0]        dac_code
);

    logic                num_valid_reg;
    logic                num_neg_reg;
    logic [NUM_W-1:0]    num_next;
    logic [NUM_W-1:0]    num_reg;
    logic                pq_valid_reg;
    logic                pq_neg_reg;
    logic [PQ_W-1:0]     pq_next;
    logic [PQ_W-1:0]     pq_reg;
    logic [QUOT_W-1:0]   quot;
    logic                code_valid_reg;
    logic [CODE_W-1:0]   code_next;
    logic [CODE_W-1:0]   code_reg;

    // Numerator; a negative term always clamps to zero, so keep only its magnitude
    assign num_next = NUM_W'(MID_CODE) * NUM_W'(term[MAG_W-1:0]);

    // Drop the power-of-two part of the denominator, then multiply by 1/625
    assign pq_next = PQ_W'(num_reg[NUM_W-1:DEN_SHIFT]) * PQ_W'(RECIP_ODD);

    assign quot = pq_reg[PQ_W-1:RECIP_SHIFT];

    always_comb
    begin
        if (pq_neg_reg)
        begin
            code_next = '0;
        end
        else if (quot > QUOT_W'(MAX_CODE))
        begin
            code_next = CODE_W'(MAX_CODE);
        end
        else
        begin
            code_next = quot[CODE_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_valid_reg  <= 1'b0;
            pq_valid_reg   <= 1'b0;
            code_valid_reg <= 1'b0;
        end
        else
        begin
            num_valid_reg  <= in_valid;
            pq_valid_reg   <= num_valid_reg;
            code_valid_reg <= pq_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        num_neg_reg <= term[TERM_W-1];
        num_reg     <= num_next;
        pq_neg_reg  <= num_neg_reg;
        pq_reg      <= pq_next;
        code_reg    <= code_next;
    end

    assign out_valid = code_valid_reg;
    assign dac_code  = code_reg;

endmodule

### bench/tb.sv
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import wtsg_pkg::*;

    // Scaling of the converter code, held in 64 bits so the products never wrap
    localparam longint CODE_MID   = 64'sd32759;
    localparam longint CODE_TOP   = 64'sd65518;
    localparam longint Q15_ONE    = 64'sd32768;
    localparam longint CODE_DEN   = Q15_ONE * 64'sd10000;
    localparam longint OFFS_SCALE = 64'sd65536;
    localparam longint unsigned QUARTER_TURN_Q30 = 64'd1686629713;

    // Results leave through the design's register pipe; leave some margin on top
    localparam int PIPE_DEPTH  = 7;
    localparam int SETTLE_CYC  = PIPE_DEPTH + 4;
    localparam int CYCLE_LIMIT = 200000;

    localparam int RANDOM_RUNS  = 26;
    localparam int ITEMS_PER_RUN = 25;

    logic                  clk;
    logic                  rst_n;
    logic                  start;
    logic                  busy;
    logic [PHASE_W-1:0]    phase_index;
    logic                  cfg_wr_en;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  done;
    logic [CODE_W-1:0]     dac_code;

    // Shadow copy of the configuration registers, updated on every write
    shape_t                  cur_shape;
    logic [AMP_W-1:0]        cur_amplitude;
    logic signed [OFFS_W-1:0] cur_offset;

    // Codes expected back, oldest first, one per accepted transaction
    logic [CODE_W-1:0] pending_codes[$];
    logic [CODE_W-1:0] oldest_code;

    int failures;
    int cycles;

    waveform_table_sample_generator_top DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .phase_index (phase_index),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .done        (done),
        .dac_code    (dac_code)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Hard stop in case the pipe loses a transaction or hangs
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Sine of 2*pi*step/P in Q.15: fold into the first quadrant, then sum the
    // Taylor series of sin(x) in Q2.30 up to the x^11 term
    function automatic int sine_q15_at(int step);
        longint unsigned quad;
        longint unsigned rem_steps;
        longint unsigned x;
        longint unsigned x_sq;
        longint unsigned term;
        longint          acc;
        int              mag;
        quad      = (4 * step) / PERIOD_STEPS;
        rem_steps = (4 * step) % PERIOD_STEPS;
        if (quad[0])
        begin
            rem_steps = PERIOD_STEPS - rem_steps;
        end
        x    = (QUARTER_TURN_Q30 * rem_steps) / PERIOD_STEPS;
        x_sq = (x * x) >> 30;
        term = x;
        acc  = longint'(x);
        for (int k = 1; k <= 5; k++)
        begin
            term = ((term * x_sq) >> 30) / ((2 * k) * (2 * k + 1));
            if (k % 2 == 1)
            begin
                acc = acc - longint'(term);
            end
            else
            begin
                acc = acc + longint'(term);
            end
        end
        if (acc < 0)
        begin
            acc = 0;
        end
        mag = int'((acc + 16384) >> 15);
        if (mag > 32768)
        begin
            mag = 32768;
        end
        return quad[1] ? -mag : mag;
    endfunction

    // Unit wave of the current shape at one step, Q.15, truncated toward zero
    function automatic int unit_wave_q15(int step);
        int half;
        half = PERIOD_STEPS / 2;
        case (cur_shape)
            SHAPE_SQUARE:   return (step < half) ? 32768 : -32768;
            SHAPE_TRIANGLE:
            begin
                if (step < half)
                begin
                    return (32768 * (half - 2 * step)) / half;
                end
                return (32768 * (2 * (step - half) - half)) / half;
            end
            SHAPE_SINE:     return sine_q15_at(step);
            default:        return (32768 * (half - step)) / half;
        endcase
    endfunction

    // Code for one phase index under the current settings: exact over the
    // common denominator, truncated toward zero, then clamped
    function automatic logic [CODE_W-1:0] predict_dac_code(logic [PHASE_W-1:0] phase);
        int     step;
        longint wave;
        longint amp;
        longint offs;
        longint numer;
        longint code;
        step  = int'(phase) % PERIOD_STEPS;
        wave  = unit_wave_q15(step);
        amp   = cur_amplitude;
        offs  = cur_offset;
        numer = CODE_MID * CODE_DEN + wave * CODE_MID * amp - offs * CODE_MID * OFFS_SCALE;
        code  = numer / CODE_DEN;
        if (code < 0)
        begin
            code = 0;
        end
        if (code > CODE_TOP)
        begin
            code = CODE_TOP;
        end
        return CODE_W'(code);
    endfunction

    // Check every strobed result against the oldest pending code
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (pending_codes.size() == 0)
            begin
                $error("dac_code: expected nothing, actual %0d", dac_code);
                failures++;
            end
            else
            begin
                oldest_code = pending_codes.pop_front();
                if (dac_code !== oldest_code)
                begin
                    $error("dac_code: expected %0d, actual %0d", oldest_code, dac_code);
                    failures++;
                end
            end
        end
    end

    // Write one register; hold the enable for one edge, then drop it.
    // Call only while the pipe is empty.
    task automatic write_register(input reg_index_t idx, input logic [CFG_DATA_W-1:0] value);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        case (idx)
            REG_WAVE_SHAPE: cur_shape     = shape_t'(value[SHAPE_W-1:0]);
            REG_AMPLITUDE:  cur_amplitude = value;
            REG_OFFSET:     cur_offset    = value;
            default:        ;
        endcase
        @(posedge clk);
    endtask

    task automatic apply_settings(input shape_t shape, input int amp, input int offs);
        write_register(REG_WAVE_SHAPE, CFG_DATA_W'(shape));
        write_register(REG_AMPLITUDE, CFG_DATA_W'(amp));
        write_register(REG_OFFSET, CFG_DATA_W'(offs));
    endtask

    // Offer one phase index and hold start until the transaction completes.
    // Start stays high when no gap follows, so back-to-back items keep it up.
    task automatic send_phase(input logic [PHASE_W-1:0] phase, input int gap);
        start       <= 1'b1;
        phase_index <= phase;
        do
            @(posedge clk);
        while (busy);
        pending_codes.push_back(predict_dac_code(phase));
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Drop start, wait for every pending code, then let the pipe settle
    task automatic drain_pipe();
        start <= 1'b0;
        while (pending_codes.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYC) @(posedge clk);
    endtask

    // No gap in a burst; otherwise as often none as a short one, now and then a long one
    function automatic int next_gap(bit burst);
        int roll;
        if (burst)
        begin
            return 0;
        end
        roll = $urandom_range(0, 99);
        if (roll < 45)
        begin
            return 0;
        end
        if (roll < 90)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 30);
    endfunction

    // Four shapes at full scale, no offset: the peaks, the zero crossing
    // at half period and the last step of the period
    task automatic test_shape_corners();
        logic [PHASE_W-1:0] corners[4];
        corners = '{6'd0, 6'd12, 6'd24, 6'd47};
        for (int s = 0; s < NUM_SHAPES; s++)
        begin
            apply_settings(shape_t'(s), 10000, 0);
            foreach (corners[c])
            begin
                send_phase(corners[c], next_gap(1'b0));
            end
            drain_pipe();
        end
    endtask

    // Oversize amplitude and offset to drive the code past both clamps,
    // plus phase indexes beyond one period that must wrap
    task automatic test_clamp_and_wrap();
        apply_settings(SHAPE_SQUARE, 16383, -8192);
        send_phase(6'd0, 0);
        send_phase(6'd63, 0);
        drain_pipe();
        apply_settings(SHAPE_SQUARE, 16383, 8191);
        send_phase(6'd24, 0);
        drain_pipe();
        apply_settings(SHAPE_TRIANGLE, 0, 5000);
        send_phase(6'd48, 1);
        drain_pipe();
        apply_settings(SHAPE_RAMP, 10000, -5000);
        send_phase(6'd55, 0);
        drain_pipe();
    endtask

    // A write to the spare register index must leave the settings alone
    task automatic test_spare_register();
        apply_settings(SHAPE_SINE, 7321, -1234);
        write_register(REG_UNUSED, 14'h3FFF);
        send_phase(6'd5, 0);
        send_phase(6'd40, 2);
        drain_pipe();
        write_register(REG_UNUSED, 14'h0000);
    endtask

    // Random settings per run, random phases with random spacing; some runs
    // go back to back, and now and then the sender holds off mid-run
    task automatic test_random_runs();
        int     amp;
        int     offs;
        bit     burst;
        logic [PHASE_W-1:0] phase;
        for (int run = 0; run < RANDOM_RUNS; run++)
        begin
            drain_pipe();
            case ($urandom_range(0, 5))
                0:       amp = 0;
                1:       amp = 10000;
                2:       amp = 16383;
                3, 4:    amp = $urandom_range(0, 10000);
                default: amp = $urandom_range(0, 16383);
            endcase
            case ($urandom_range(0, 7))
                0:       offs = -5000;
                1:       offs = 5000;
                2:       offs = -8192;
                3:       offs = 8191;
                4:       offs = 0;
                5, 6:    offs = int'($urandom_range(0, 10000)) - 5000;
                default: offs = $urandom_range(0, 16383);
            endcase
            apply_settings(shape_t'($urandom_range(0, 3)), amp, offs);
            if ($urandom_range(0, 7) == 0)
            begin
                write_register(REG_UNUSED, CFG_DATA_W'($urandom));
            end
            burst = ($urandom_range(0, 3) == 0);
            for (int n = 0; n < ITEMS_PER_RUN; n++)
            begin
                if ($urandom_range(0, 7) == 0)
                begin
                    phase = PHASE_W'($urandom_range(PERIOD_STEPS, 63));
                end
                else
                begin
                    phase = PHASE_W'($urandom_range(0, PERIOD_STEPS - 1));
                end
                send_phase(phase, next_gap(burst));
                // Hold off until the pipe is empty, then carry on
                if ($urandom_range(0, 59) == 0)
                begin
                    drain_pipe();
                end
            end
        end
        drain_pipe();
    endtask

    initial
    begin
        rst_n         = 1'b0;
        start         = 1'b0;
        phase_index   = '0;
        cfg_wr_en     = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        cur_shape     = SHAPE_SQUARE;
        cur_amplitude = '0;
        cur_offset    = '0;

        // Hold reset from time zero, then release it once
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: zero amplitude and offset give the midpoint code
        send_phase(6'd17, 0);
        drain_pipe();

        test_shape_corners();
        test_clamp_and_wrap();
        test_spare_register();
        test_random_runs();

        if (failures == 0)
        begin
            $display("TB_OK");
        end
        else
        begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
